@@ rtl/rba_pkg.sv @@
// rba_pkg: shared types and constants for the reference-counted bank allocator
// holds command and status codes and the fixed port field widths
// no dependencies
`timescale 1ns / 1ps

package rba_pkg;

  // fixed field widths of the request and result words
  localparam int CMD_W       = 1;
  localparam int ASSET_W     = 16;
  localparam int BANK_NUM_W  = 4;
  localparam int STATUS_W    = 3;
  localparam int INDEX_OUT_W = 4;
  localparam int COUNT_OUT_W = 16;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request commands
  localparam cmd_t CMD_ADD    = 1'b0;
  localparam cmd_t CMD_REMOVE = 1'b1;

  // result status codes
  localparam status_t ST_FOUND   = 3'd0;
  localparam status_t ST_CLAIMED = 3'd1;
  localparam status_t ST_FULL    = 3'd2;
  localparam status_t ST_HELD    = 3'd3;
  localparam status_t ST_FREED   = 3'd4;
  localparam status_t ST_BAD     = 3'd5;

endpackage

@@ rtl/rba_ram.sv @@
// rba_ram: generic single-port-write, single-port-read memory
// read data is registered; no dependencies
`timescale 1ns / 1ps

module rba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/refcounted_bank_allocator_core.sv @@
// refcounted_bank_allocator_core: reference-counted bank table, one request at a time
// add: reads one bank per cycle through the single read port, ending at an owner match
//   or after the last bank; remove: bank read on accept, decrement written in S_REMOVE
// each result passes S_FINISH into the output register; the next request can be taken in
//   the cycle after that; S_FINISH holds while the last word waits with out_ready low
// reset clears the valid bits, so every bank is free; the RAM itself is never cleared
`timescale 1ns / 1ps

module refcounted_bank_allocator_core #(
  parameter int BANK_COUNT = 16,
  parameter int ID_BITS    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rba_pkg::cmd_t                      command,
  input  logic [rba_pkg::ASSET_W-1:0]        asset_id,
  input  logic [rba_pkg::BANK_NUM_W-1:0]     bank_number,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rba_pkg::status_t                   status,
  output logic [rba_pkg::INDEX_OUT_W-1:0]    bank_index,
  output logic [rba_pkg::COUNT_OUT_W-1:0]    ref_count
);

  import rba_pkg::*;

  localparam int IDX_W  = $clog2(BANK_COUNT);
  localparam int SCAN_W = $clog2(BANK_COUNT + 1);
  localparam int WORD_W = ID_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
  localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(BANK_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REMOVE,
    S_FINISH
  } state_t;

  state_t                  state;
  logic [BANK_COUNT-1:0]   bank_valid;
  logic [ID_BITS-1:0]      id_r;
  logic [IDX_W-1:0]        bank_r;
  logic [SCAN_W-1:0]       scan_idx;
  logic [IDX_W-1:0]        chk_idx;
  logic                    chk_vld;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  status_t                 res_status;
  logic [INDEX_OUT_W-1:0]  res_index;
  logic [COUNT_OUT_W-1:0]  res_count;

  // ram port signals
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [WORD_W-1:0]       ram_rdata;

  // request decode
  logic [31:0]             asset_ext;
  logic [ID_BITS-1:0]      id_in;
  logic [31:0]             bank_ext;
  logic                    bank_in_range;
  logic [IDX_W-1:0]        bank_sel;
  logic                    bank_ok;

  // scan and update helpers
  logic [ID_BITS-1:0]      rd_owner;
  logic [COUNT_BITS-1:0]   rd_refs;
  logic [COUNT_BITS-1:0]   inc_refs;
  logic [COUNT_BITS-1:0]   dec_refs;
  logic                    chk_bank_valid;
  logic                    hit;
  logic                    cur_free;
  logic                    scan_last;
  logic                    claim_ok;
  logic [IDX_W-1:0]        claim_idx;
  logic                    scan_more;
  logic [31:0]             chk_ext;
  logic [31:0]             claim_ext;
  logic [31:0]             bank_r_ext;
  logic [31:0]             inc_ext;
  logic [31:0]             dec_ext;

  assign in_ready = (state == S_IDLE);

  // input field decode
  assign asset_ext     = 32'(asset_id);
  assign id_in         = asset_ext[ID_BITS-1:0];
  assign bank_ext      = 32'(bank_number);
  assign bank_in_range = (bank_ext < 32'(BANK_COUNT));
  assign bank_sel      = bank_ext[IDX_W-1:0];
  assign bank_ok       = bank_in_range && bank_valid[bank_sel];

  // ram word split and count arithmetic
  assign rd_owner = ram_rdata[WORD_W-1 -: ID_BITS];
  assign rd_refs  = ram_rdata[COUNT_BITS-1:0];
  assign inc_refs = (rd_refs == CNT_MAX) ? rd_refs : rd_refs + CNT_ONE;
  assign dec_refs = (rd_refs != '0) ? rd_refs - CNT_ONE : rd_refs;

  // compare stage of the scan, one entry behind the read address
  assign chk_bank_valid = bank_valid[chk_idx];
  assign hit            = chk_vld && chk_bank_valid && (rd_owner == id_r);
  assign cur_free       = chk_vld && !chk_bank_valid;
  assign scan_last      = chk_vld && (chk_idx == LAST_IDX);
  assign claim_ok       = free_found || cur_free;
  assign claim_idx      = free_found ? free_idx : chk_idx;
  assign scan_more      = (scan_idx < SCAN_W'(BANK_COUNT));

  // index and count extension to the result field widths
  assign chk_ext    = 32'(chk_idx);
  assign claim_ext  = 32'(claim_idx);
  assign bank_r_ext = 32'(bank_r);
  assign inc_ext    = 32'(inc_refs);
  assign dec_ext    = 32'(dec_refs);

  // ram address and write control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = {rd_owner, inc_refs};
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (bank_in_range) begin
          ram_raddr = bank_sel;
        end
      end
      S_SCAN: begin
        if (scan_more) begin
          ram_raddr = scan_idx[IDX_W-1:0];
        end
        if (hit) begin
          ram_we = 1'b1;
        end else if (scan_last && claim_ok) begin
          ram_we    = 1'b1;
          ram_waddr = claim_idx;
          ram_wdata = {id_r, CNT_ONE};
        end
      end
      S_REMOVE: begin
        ram_we    = 1'b1;
        ram_waddr = bank_r;
        ram_wdata = {rd_owner, dec_refs};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // owner and reference count store
  rba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BANK_COUNT)
  ) u_bank_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state machine, valid bits and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bank_valid <= '0;
      chk_vld    <= 1'b0;
      free_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            id_r       <= id_in;
            bank_r     <= bank_sel;
            scan_idx   <= '0;
            chk_vld    <= 1'b0;
            free_found <= 1'b0;
            if (command == CMD_ADD) begin
              state <= S_SCAN;
            end else if (bank_ok) begin
              state <= S_REMOVE;
            end else begin
              res_status <= ST_BAD;
              res_index  <= bank_number;
              res_count  <= '0;
              state      <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            scan_idx <= scan_idx + SCAN_W'(1);
          end
          chk_vld <= scan_more;
          chk_idx <= scan_idx[IDX_W-1:0];
          if (cur_free && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
          if (hit) begin
            res_status <= ST_FOUND;
            res_index  <= chk_ext[INDEX_OUT_W-1:0];
            res_count  <= inc_ext[COUNT_OUT_W-1:0];
            state      <= S_FINISH;
          end else if (scan_last) begin
            if (claim_ok) begin
              bank_valid[claim_idx] <= 1'b1;
              res_status <= ST_CLAIMED;
              res_index  <= claim_ext[INDEX_OUT_W-1:0];
              res_count  <= COUNT_OUT_W'(1);
            end else begin
              res_status <= ST_FULL;
              res_index  <= '0;
              res_count  <= '0;
            end
            state <= S_FINISH;
          end
        end
        S_REMOVE: begin
          res_index <= bank_r_ext[INDEX_OUT_W-1:0];
          if (dec_refs == '0) begin
            bank_valid[bank_r] <= 1'b0;
            res_status <= ST_FREED;
            res_count  <= '0;
          end else begin
            res_status <= ST_HELD;
            res_count  <= dec_ext[COUNT_OUT_W-1:0];
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            status     <= res_status;
            bank_index <= res_index;
            ref_count  <= res_count;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the ram is never written in the cycle a new request is taken
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !in_ready)
    else $error("bank ram written while accepting a request");

  // a match is only reported on a bank in use
  a_hit_on_valid: assert property (@(posedge clk) disable iff (rst)
    hit |-> bank_valid[chk_idx])
    else $error("owner match on a free bank");

  // the scan pointer never runs past the table
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= SCAN_W'(BANK_COUNT)))
    else $error("scan pointer beyond bank count");

  // a claimed bank is marked in use once the scan ends
  a_claim_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !hit && scan_last && claim_ok) |=> bank_valid[$past(claim_idx)])
    else $error("claimed bank not marked valid");

  // a freed bank drops its valid bit
  a_free_clears_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_REMOVE && dec_refs == '0) |=> !bank_valid[$past(bank_r)])
    else $error("freed bank still marked valid");

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for refcounted_bank_allocator_core, with a bank-table scoreboard
// drives add/remove requests with random gaps and stalls and checks every result word in order
// depends on rba_pkg and the core, run at the default table size and field widths
`timescale 1ns / 1ps

module tb_top;
  import rba_pkg::*;

  localparam int BANK_COUNT  = 16;
  localparam int ID_BITS     = 16;
  localparam int COUNT_BITS  = 16;
  localparam int LATENCY     = BANK_COUNT + 3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_CAP  = 150;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    status_t                  status;
    logic [INDEX_OUT_W-1:0]   index;
    logic [COUNT_OUT_W-1:0]   count;
  } bank_result_t;

  // shadow copy of the bank table plus the queue of result words still owed
  class bank_ledger;
    bit                  used[BANK_COUNT];
    logic [ID_BITS-1:0]  owner[BANK_COUNT];
    int unsigned         refs[BANK_COUNT];
    bank_result_t        due_results[$];
    int                  faults;

    function new();
      foreach (used[i]) begin
        used[i] = 1'b0;
        owner[i] = '0;
        refs[i] = 0;
      end
      faults = 0;
    endfunction

    // apply one request to the shadow table and return the word it must produce
    function bank_result_t predict_request(cmd_t cmd, logic [ASSET_W-1:0] id,
                                           logic [BANK_NUM_W-1:0] bank);
      bank_result_t r;
      int hit;
      int slot;
      int unsigned top;
      logic [ID_BITS-1:0] key;
      top = (1 << COUNT_BITS) - 1;
      key = id[ID_BITS-1:0];
      r.status = ST_FULL;
      r.index = '0;
      r.count = '0;
      if (cmd == CMD_ADD) begin
        hit = -1;
        slot = -1;
        for (int i = 0; i < BANK_COUNT; i++) begin
          if (hit < 0 && used[i] && owner[i] == key) hit = i;
          if (slot < 0 && !used[i]) slot = i;
        end
        if (hit >= 0) begin
          // existing owner, count sticks at its maximum
          if (refs[hit] < top) refs[hit]++;
          r.status = ST_FOUND;
          r.index = hit[INDEX_OUT_W-1:0];
          r.count = COUNT_OUT_W'(refs[hit]);
        end else if (slot >= 0) begin
          used[slot] = 1'b1;
          owner[slot] = key;
          refs[slot] = 1;
          r.status = ST_CLAIMED;
          r.index = slot[INDEX_OUT_W-1:0];
          r.count = COUNT_OUT_W'(1);
        end
      end else begin
        r.index = INDEX_OUT_W'(bank);
        if (bank >= BANK_COUNT || !used[bank]) begin
          r.status = ST_BAD;
        end else begin
          if (refs[bank] > 0) refs[bank]--;
          if (refs[bank] == 0) begin
            used[bank] = 1'b0;
            r.status = ST_FREED;
          end else begin
            r.status = ST_HELD;
            r.count = COUNT_OUT_W'(refs[bank]);
          end
        end
      end
      return r;
    endfunction

    function void note_request(cmd_t cmd, logic [ASSET_W-1:0] id,
                               logic [BANK_NUM_W-1:0] bank);
      due_results.push_back(predict_request(cmd, id, bank));
    endfunction

    function void check_word(status_t st, logic [INDEX_OUT_W-1:0] idx,
                             logic [COUNT_OUT_W-1:0] cnt);
      bank_result_t want;
      if (due_results.size() == 0) begin
        faults++;
        if (faults <= REPORT_CAP)
          $display("%0t: unexpected result word: status=%0d bank=%0d count=%0d",
                   $time, st, idx, cnt);
        return;
      end
      want = due_results.pop_front();
      if (want.status !== st || want.index !== idx || want.count !== cnt) begin
        faults++;
        if (faults <= REPORT_CAP)
          $display({"%0t: mismatch: expected status=%0d bank=%0d count=%0d,",
                    " got status=%0d bank=%0d count=%0d"},
                   $time, want.status, want.index, want.count, st, idx, cnt);
      end
    endfunction

    // random bank that currently holds references, -1 if none
    function int any_live_bank();
      int live[$];
      foreach (used[i]) if (used[i]) live.push_back(i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  cmd_t                    command;
  logic [ASSET_W-1:0]      asset_id;
  logic [BANK_NUM_W-1:0]   bank_number;
  logic                    out_valid;
  logic                    out_ready;
  status_t                 status;
  logic [INDEX_OUT_W-1:0]  bank_index;
  logic [COUNT_OUT_W-1:0]  ref_count;

  bank_ledger  ledger = new();
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int          cycles = 0;
  logic [ASSET_W-1:0] id_pool[$];

  refcounted_bank_allocator_core #(
    .BANK_COUNT (BANK_COUNT),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .asset_id    (asset_id),
    .bank_number (bank_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .bank_index  (bank_index),
    .ref_count   (ref_count)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  // result word monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.check_word(status, bank_index, ref_count);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("refcounted_bank_allocator_core verification failed");
      $finish;
    end
  end

  // send one request word and record it once accepted
  task automatic send_request(input cmd_t cmd, input logic [ASSET_W-1:0] id,
                              input logic [BANK_NUM_W-1:0] bank);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command = cmd;
    asset_id = id;
    bank_number = bank;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(cmd, id, bank);
    @(negedge clk);
  endtask

  // hold the sender until every owed word has come back
  task automatic drain();
    in_valid = 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int add_pct;
    int live;
    logic [ASSET_W-1:0] id;
    logic [BANK_NUM_W-1:0] bank;

    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_ADD;
    asset_id = '0;
    bank_number = '0;
    out_ready = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: empty remove, id extremes, repeated hits, free, stale bank, full table
    send_request(CMD_REMOVE, 16'hFFFF, 4'd0);
    send_request(CMD_ADD, 16'h0000, 4'hF);
    send_request(CMD_ADD, 16'hFFFF, 4'h0);
    repeat (7) send_request(CMD_ADD, 16'h0000, 4'h0);
    send_request(CMD_REMOVE, 16'h0000, 4'd1);
    send_request(CMD_REMOVE, 16'h0000, 4'd1);
    for (int k = 0; k < BANK_COUNT - 1; k++)
      send_request(CMD_ADD, 16'h0001 << k, 4'h0);
    send_request(CMD_ADD, 16'h5A5A, 4'h0);
    send_request(CMD_ADD, 16'h0000, 4'h0);
    send_request(CMD_REMOVE, 16'h0000, 4'hF);
    send_request(CMD_REMOVE, 16'h0000, 4'h0);
    drain();

    // random phases: fill-heavy and drain-heavy, small id pools so ids repeat
    for (int ph = 0; ph < PHASES; ph++) begin
      quiet = (ph == 3 || ph == 6);
      add_pct = (ph % 2 == 0) ? 70 : 35;
      id_pool.delete();
      repeat ($urandom_range(4, 30)) id_pool.push_back(ASSET_W'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < add_pct) begin
          if ($urandom_range(0, 9) == 0)
            id = ASSET_W'($urandom);
          else
            id = id_pool[$urandom_range(0, id_pool.size() - 1)];
          send_request(CMD_ADD, id, BANK_NUM_W'($urandom));
        end else begin
          live = ledger.any_live_bank();
          if (live >= 0 && $urandom_range(0, 9) != 0)
            bank = live[BANK_NUM_W-1:0];
          else
            bank = BANK_NUM_W'($urandom);
          send_request(CMD_REMOVE, ASSET_W'($urandom), bank);
        end
      end
      drain();
    end
    quiet = 1'b0;

    // let any stray word show up before deciding
    in_valid = 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);
    if (ledger.faults == 0)
      $display("refcounted_bank_allocator_core verification clean");
    else
      $display("refcounted_bank_allocator_core verification failed");
    $finish;
  end

endmodule

@@ refcounted_bank_allocator_core.f @@
rtl/rba_pkg.sv
rtl/rba_ram.sv
rtl/refcounted_bank_allocator_core.sv
tb/sv/tb_top.sv
